>>> hw/rtl/sswfm_pkg.sv
// Shared types and constants for the SPI to single-wire frame mux.
package sswfm_pkg;

  localparam int QUEUE_BITS_DEF = 32;
  localparam int CHUNK_BITS_DEF = 24;
  localparam int HDR_BITS       = 8;
  localparam int LEN_BITS       = 5;
  localparam int BODY_BITS      = (2 ** LEN_BITS) - 1;
  localparam int HDR_CNT_W      = $clog2(HDR_BITS + 1);

  typedef enum logic [1:0] {
    MODE_RISE  = 2'd0,
    MODE_FALL  = 2'd1,
    MODE_SLOT  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SENT = 2'd1,
    ACT_POLL = 2'd2,
    ACT_SKIP = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       mosi_bit;
    logic       reply_present;
    logic       reply_bit;
  } item_t;

  typedef struct packed {
    logic       miso_bit;
    logic       slot_channel;
    logic [1:0] slot_action;
    logic       sent_bit;
    logic       bit_stored;
    logic       overflow_flag;
  } result_t;

endpackage

>>> hw/rtl/sswfm_in_reg.sv
// Input register stage: holds one accepted event until the core takes it.
module sswfm_in_reg import sswfm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_q;
  item_t item_q;

  assign in_ready   = !valid_q || advance;
  assign item_valid = valid_q;
  assign item       = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q <= '0;
    end else if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

endmodule

>>> hw/rtl/sswfm_core.sv
// Frame collection, per-channel queues, MISO shifter and slot service logic.
module sswfm_core import sswfm_pkg::*; #(
  parameter int QUEUE_BITS = QUEUE_BITS_DEF,
  parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  localparam int QCW  = $clog2(QUEUE_BITS + 1);
  localparam int CW   = $clog2(CHUNK_BITS + 1);
  localparam int MW   = (QCW > CW) ? QCW : CW;
  localparam int SW   = ((QCW > LEN_BITS) ? QCW : LEN_BITS) + 1;
  localparam int TXW  = HDR_BITS + CHUNK_BITS;
  localparam int TXCW = $clog2(TXW + 1);
  localparam int AW   = QUEUE_BITS + BODY_BITS;

  logic [TXW-1:0]        tx_shift, tx_shift_next;
  logic [TXCW-1:0]       tx_count, tx_count_next;
  logic [HDR_BITS-1:0]   hdr_shift, hdr_shift_next;
  logic [HDR_CNT_W-1:0]  hdr_count, hdr_count_next;
  logic [BODY_BITS-1:0]  body_shift, body_shift_next;
  logic [LEN_BITS-1:0]   body_count, body_count_next;
  logic [QUEUE_BITS-1:0] send_q [2];
  logic [QUEUE_BITS-1:0] send_q_next [2];
  logic [QCW-1:0]        send_cnt [2];
  logic [QCW-1:0]        send_cnt_next [2];
  logic [QUEUE_BITS-1:0] recv_st [2];
  logic [QUEUE_BITS-1:0] recv_st_next [2];
  logic [QCW-1:0]        recv_cnt [2];
  logic [QCW-1:0]        recv_cnt_next [2];
  logic                  cur_ch, cur_ch_next;
  logic                  ovf, ovf_next;

  always_comb begin
    logic                         who;
    logic [1:0]                   ch;
    logic [LEN_BITS-1:0]          bc_new;
    logic [SW-1:0]                sum;
    logic [AW-1:0]                app;
    logic [QUEUE_BITS-1:0]        rs;
    logic [QCW-1:0]               rc;
    logic [QUEUE_BITS+CHUNK_BITS-1:0] rs_wide;
    logic [MW-1:0]                n_m;
    logic [CW-1:0]                n_c;
    logic [CHUNK_BITS-1:0]        data;

    tx_shift_next   = tx_shift;
    tx_count_next   = tx_count;
    hdr_shift_next  = hdr_shift;
    hdr_count_next  = hdr_count;
    body_shift_next = body_shift;
    body_count_next = body_count;
    send_q_next     = send_q;
    send_cnt_next   = send_cnt;
    recv_st_next    = recv_st;
    recv_cnt_next   = recv_cnt;
    cur_ch_next     = cur_ch;
    ovf_next        = ovf;
    who     = ~cur_ch;
    ch      = hdr_shift[7:6];
    bc_new  = body_count + LEN_BITS'(1);
    sum     = '0;
    app     = '0;
    rs      = '0;
    rc      = '0;
    rs_wide = '0;
    n_m     = '0;
    n_c     = '0;
    data    = '0;
    res     = '0;

    unique case (mode_t'(item.mode))
      MODE_RISE: begin
        if (tx_count != '0) begin
          res.miso_bit  = tx_shift[0];
          tx_shift_next = tx_shift >> 1;
          tx_count_next = tx_count - TXCW'(1);
        end
      end
      MODE_FALL: begin
        if (hdr_count == '0 && !item.mosi_bit) begin
          // idle line: ignore
        end else if (hdr_count < HDR_CNT_W'(HDR_BITS)) begin
          hdr_shift_next[hdr_count[$clog2(HDR_BITS)-1:0]] = item.mosi_bit;
          hdr_count_next = hdr_count + HDR_CNT_W'(1);
          if (hdr_count_next == HDR_CNT_W'(HDR_BITS) &&
              hdr_shift_next[LEN_BITS:1] == '0) begin
            hdr_shift_next = '0;
            hdr_count_next = '0;
          end
        end else begin
          body_shift_next[body_count] = item.mosi_bit;
          body_count_next = bc_new;
          if (bc_new >= hdr_shift[LEN_BITS:1]) begin
            for (int c = 0; c < 2; c++) begin
              if (ch == 2'(c)) begin
                sum = SW'(send_cnt[c]) + SW'(bc_new);
                if (sum > SW'(QUEUE_BITS)) begin
                  ovf_next = 1'b1;
                end else begin
                  app = AW'(body_shift_next) << send_cnt[c];
                  send_q_next[c]   = send_q[c] | app[QUEUE_BITS-1:0];
                  send_cnt_next[c] = QCW'(sum);
                end
              end
            end
            hdr_shift_next  = '0;
            hdr_count_next  = '0;
            body_shift_next = '0;
            body_count_next = '0;
          end
        end
      end
      MODE_SLOT: begin
        cur_ch_next      = who;
        res.slot_channel = who;
        for (int c = 0; c < 2; c++) begin
          if (who == 1'(c)) begin
            rs = recv_st[c];
            rc = recv_cnt[c];
            if (tx_count == '0 && rc != '0) begin
              n_m = (MW'(rc) > MW'(CHUNK_BITS)) ? MW'(CHUNK_BITS) : MW'(rc);
              n_c = CW'(n_m);
              rs_wide = (QUEUE_BITS + CHUNK_BITS)'(rs);
              for (int i = 0; i < CHUNK_BITS; i++) begin
                data[i] = rs_wide[i] && (CW'(i) < n_c);
              end
              tx_shift_next = {data, 1'b0, who, LEN_BITS'(n_c), 1'b1};
              tx_count_next = TXCW'(HDR_BITS) + TXCW'(n_c);
              rc = rc - QCW'(n_m);
              rs = rs >> QCW'(n_m);
            end
            if (send_cnt[c] != '0) begin
              res.slot_action  = ACT_SENT;
              res.sent_bit     = send_q[c][0];
              send_q_next[c]   = send_q[c] >> 1;
              send_cnt_next[c] = send_cnt[c] - QCW'(1);
            end else if (rc >= QCW'(QUEUE_BITS)) begin
              res.slot_action = ACT_SKIP;
            end else begin
              res.slot_action = ACT_POLL;
              if (item.reply_present) begin
                rs = rs | (QUEUE_BITS'(item.reply_bit) << rc);
                rc = rc + QCW'(1);
                res.bit_stored = 1'b1;
              end
            end
            recv_st_next[c]  = rs;
            recv_cnt_next[c] = rc;
          end
        end
      end
      MODE_SPARE: begin
        // no state change
      end
    endcase

    res.overflow_flag = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift   <= '0;
      tx_count   <= '0;
      hdr_shift  <= '0;
      hdr_count  <= '0;
      body_shift <= '0;
      body_count <= '0;
      send_q     <= '{default: '0};
      send_cnt   <= '{default: '0};
      recv_st    <= '{default: '0};
      recv_cnt   <= '{default: '0};
      cur_ch     <= 1'b0;
      ovf        <= 1'b0;
    end else if (fire) begin
      tx_shift   <= tx_shift_next;
      tx_count   <= tx_count_next;
      hdr_shift  <= hdr_shift_next;
      hdr_count  <= hdr_count_next;
      body_shift <= body_shift_next;
      body_count <= body_count_next;
      send_q     <= send_q_next;
      send_cnt   <= send_cnt_next;
      recv_st    <= recv_st_next;
      recv_cnt   <= recv_cnt_next;
      cur_ch     <= cur_ch_next;
      ovf        <= ovf_next;
    end
  end

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared outside reset");

  a_send_bound: assert property (@(posedge clk) disable iff (rst)
    send_cnt[0] <= QCW'(QUEUE_BITS) && send_cnt[1] <= QCW'(QUEUE_BITS))
    else $error("send queue count beyond capacity");

  a_recv_bound: assert property (@(posedge clk) disable iff (rst)
    recv_cnt[0] <= QCW'(QUEUE_BITS) && recv_cnt[1] <= QCW'(QUEUE_BITS))
    else $error("receive store count beyond capacity");

  a_body_after_hdr: assert property (@(posedge clk) disable iff (rst)
    body_count != '0 |-> hdr_count == HDR_CNT_W'(HDR_BITS))
    else $error("body bits collected without a full header");

  a_tx_bound: assert property (@(posedge clk) disable iff (rst)
    tx_count <= TXCW'(TXW))
    else $error("MISO count beyond shifter width");

endmodule

>>> hw/rtl/sswfm_out_reg.sv
// Result register: holds one result until the output transaction completes.
module sswfm_out_reg import sswfm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  result_t res_in,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic    valid_q;
  result_t res_q;

  assign advance   = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign res_out   = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_in;
    end
  end

endmodule

>>> hw/rtl/spi_to_single_wire_frame_mux_unit.sv
// Top level of the SPI to single-wire frame mux.
// Path: an accepted transaction waits in the input register until the core fires, and
// its result is then loaded into the result register.
// Throughput: one event per cycle while out_ready is high; the input register and result
// register each hold one transaction, so one input is taken while a result waits.
// Reset: synchronous rst clears all queues, counters, shifters and the overflow flag.
module spi_to_single_wire_frame_mux_unit import sswfm_pkg::*; #(
  parameter int QUEUE_BITS = QUEUE_BITS_DEF,
  parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic       mosi_bit,
  input  logic       reply_present,
  input  logic       reply_bit,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       miso_bit,
  output logic       slot_channel,
  output logic [1:0] slot_action,
  output logic       sent_bit,
  output logic       bit_stored,
  output logic       overflow_flag
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  result_t res;
  result_t res_out;

  assign in_item = '{mode: mode, mosi_bit: mosi_bit, reply_present: reply_present,
                     reply_bit: reply_bit};
  assign fire    = item_valid && advance;

  sswfm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sswfm_core #(
    .QUEUE_BITS (QUEUE_BITS),
    .CHUNK_BITS (CHUNK_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res)
  );

  sswfm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_in    (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign miso_bit      = res_out.miso_bit;
  assign slot_channel  = res_out.slot_channel;
  assign slot_action   = res_out.slot_action;
  assign sent_bit      = res_out.sent_bit;
  assign bit_stored    = res_out.bit_stored;
  assign overflow_flag = res_out.overflow_flag;

endmodule
